>>> rtl/rmd_pkg.sv
// Package for the RIPEMD-320 hash unit: queue entry type, state codes,
// round constant tables and the round helper functions. No dependencies.
package rmd_pkg;

  localparam int NumWords   = 10;
  localparam int BlockWords = 16;
  localparam int Rounds     = 80;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        xtra80;
    logic [5:0]  bits;
  } rmd_entry_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_COMP = 5'b01000,
    ST_OUT  = 5'b10000
  } rmd_state_t;

  localparam logic [31:0] IV_TAB [0:9] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0,
    32'h76543210, 32'hFEDCBA98, 32'h89ABCDEF, 32'h01234567, 32'h3C2D1E0F
  };
  localparam logic [31:0] KL_TAB [0:4] = '{
    32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E
  };
  localparam logic [31:0] KR_TAB [0:4] = '{
    32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000
  };
  localparam logic [3:0] RL_TAB [0:79] = '{
    0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
    7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
    3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
    1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
    4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13
  };
  localparam logic [3:0] RR_TAB [0:79] = '{
    5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
    6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
    15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
    8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
    12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11
  };
  localparam logic [4:0] SL_TAB [0:79] = '{
    11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
    7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
    11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
    11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
    9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6
  };
  localparam logic [4:0] SR_TAB [0:79] = '{
    8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
    9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
    9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
    15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
    8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11
  };

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] bool_fn(input logic [2:0] g, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z);
    logic [31:0] r;
    case (g)
      3'd0:    r = x ^ y ^ z;
      3'd1:    r = (x & y) | (~x & z);
      3'd2:    r = (x | ~y) ^ z;
      3'd3:    r = (x & z) | (y & ~z);
      default: r = x ^ (y | ~z);
    endcase
    return r;
  endfunction

endpackage

>>> rtl/rmd_front.sv
// Front end of the RIPEMD-320 hash unit: classifies input beats, masks and
// pads the last word, and queues them in a two-entry queue. Uses rmd_pkg.
module rmd_front import rmd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_of_message,
  output logic        q_valid,
  output rmd_entry_t  q_entry,
  input  logic        q_pop
);

  rmd_entry_t ent_r [0:1];
  rmd_entry_t ent_nxt;
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  always_comb begin
    ent_nxt.word   = in_data_word;
    ent_nxt.last   = in_last_of_message;
    ent_nxt.xtra80 = 1'b0;
    ent_nxt.bits   = 6'd32;
    if (in_last_of_message) begin
      case (in_byte_count)
        3'd0: begin
          ent_nxt.word = 32'h00000080;
          ent_nxt.bits = 6'd0;
        end
        3'd1: begin
          ent_nxt.word = {16'h0000, 8'h80, in_data_word[7:0]};
          ent_nxt.bits = 6'd8;
        end
        3'd2: begin
          ent_nxt.word = {8'h00, 8'h80, in_data_word[15:0]};
          ent_nxt.bits = 6'd16;
        end
        3'd3: begin
          ent_nxt.word = {8'h80, in_data_word[23:0]};
          ent_nxt.bits = 6'd24;
        end
        default: ent_nxt.xtra80 = 1'b1;
      endcase
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_entry  = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push  ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= ent_nxt;
    end
  end

endmodule

>>> rtl/rmd_back.sv
// Back end of the RIPEMD-320 hash unit: block buffer memory, padding
// sequencer, one-round-per-cycle compression and digest output. Uses rmd_pkg.
module rmd_back import rmd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  rmd_entry_t  q_entry,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [3:0]  out_word_index,
  output logic        out_last_word
);

  logic [31:0] buf_mem [0:BlockWords-1];
  logic [31:0] ml_r, mr_r;
  logic [31:0] cv_r [0:NumWords-1];
  logic [31:0] cv_nxt [0:NumWords-1];
  logic [31:0] wv_r [0:NumWords-1];
  logic [31:0] wv_nxt [0:NumWords-1];
  logic [31:0] nw [0:NumWords-1];
  rmd_state_t  st_r, st_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [63:0] len_r, len_nxt;
  logic [6:0]  rnd_r, rnd_nxt, rd_rnd;
  logic [3:0]  oidx_r, oidx_nxt;
  logic        pad_r, pad_nxt, pend_r, pend_nxt, hi_r, hi_nxt, fin_r, fin_nxt;
  logic        we;
  logic [31:0] wdata, tl, tr;
  logic [2:0]  gl, gr;
  logic [31:0] tmp;

  assign gl = 3'(rnd_r >> 4);
  assign gr = 3'd4 - gl;
  assign tl = rotl(wv_r[0] + bool_fn(gl, wv_r[1], wv_r[2], wv_r[3]) + ml_r + KL_TAB[gl],
                   SL_TAB[rnd_r]) + wv_r[4];
  assign tr = rotl(wv_r[5] + bool_fn(gr, wv_r[6], wv_r[7], wv_r[8]) + mr_r + KR_TAB[gl],
                   SR_TAB[rnd_r]) + wv_r[9];

  always_comb begin
    nw[0] = wv_r[4];
    nw[1] = tl;
    nw[2] = wv_r[1];
    nw[3] = rotl(wv_r[2], 5'd10);
    nw[4] = wv_r[3];
    nw[5] = wv_r[9];
    nw[6] = tr;
    nw[7] = wv_r[6];
    nw[8] = rotl(wv_r[7], 5'd10);
    nw[9] = wv_r[8];
    tmp   = 32'h0;
    case (rnd_r)
      7'd15: begin tmp = nw[1]; nw[1] = nw[6]; nw[6] = tmp; end
      7'd31: begin tmp = nw[3]; nw[3] = nw[8]; nw[8] = tmp; end
      7'd47: begin tmp = nw[0]; nw[0] = nw[5]; nw[5] = tmp; end
      7'd63: begin tmp = nw[2]; nw[2] = nw[7]; nw[7] = tmp; end
      7'd79: begin tmp = nw[4]; nw[4] = nw[9]; nw[9] = tmp; end
      default: tmp = 32'h0;
    endcase
  end

  always_comb begin
    st_nxt   = st_r;
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    rnd_nxt  = rnd_r;
    oidx_nxt = oidx_r;
    pad_nxt  = pad_r;
    pend_nxt = pend_r;
    hi_nxt   = hi_r;
    fin_nxt  = fin_r;
    cv_nxt   = cv_r;
    wv_nxt   = wv_r;
    we       = 1'b0;
    wdata    = 32'h0;
    q_pop    = 1'b0;
    rd_rnd   = (rnd_r == 7'(Rounds - 1)) ? 7'd0 : rnd_r + 7'd1;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          we      = 1'b1;
          wdata   = q_entry.word;
          len_nxt = len_r + {58'h0, q_entry.bits};
          pos_nxt = pos_r + 4'd1;
          if (q_entry.last) begin
            pad_nxt  = 1'b1;
            pend_nxt = q_entry.xtra80;
          end
          if (pos_r == 4'd15) begin
            st_nxt = ST_LOAD;
          end else if (q_entry.last) begin
            st_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        we      = 1'b1;
        pos_nxt = pos_r + 4'd1;
        if (pend_r) begin
          wdata    = 32'h00000080;
          pend_nxt = 1'b0;
        end else if (hi_r) begin
          wdata   = len_r[63:32];
          hi_nxt  = 1'b0;
          fin_nxt = 1'b1;
        end else if (pos_r == 4'd14) begin
          wdata  = len_r[31:0];
          hi_nxt = 1'b1;
        end
        if (pos_r == 4'd15) begin
          st_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        rd_rnd  = 7'd0;
        wv_nxt  = cv_r;
        rnd_nxt = 7'd0;
        st_nxt  = ST_COMP;
      end
      ST_COMP: begin
        wv_nxt  = nw;
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == 7'(Rounds - 1)) begin
          rnd_nxt = 7'd0;
          for (int k = 0; k < NumWords; k++) begin
            cv_nxt[k] = cv_r[k] + nw[k];
          end
          if (fin_r) begin
            st_nxt = ST_OUT;
          end else if (pad_r) begin
            st_nxt = ST_PAD;
          end else begin
            st_nxt = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          if (oidx_r == 4'(NumWords - 1)) begin
            oidx_nxt = 4'd0;
            cv_nxt   = IV_TAB;
            len_nxt  = 64'h0;
            pos_nxt  = 4'd0;
            pad_nxt  = 1'b0;
            fin_nxt  = 1'b0;
            st_nxt   = ST_IDLE;
          end else begin
            oidx_nxt = oidx_r + 4'd1;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_valid       = (st_r == ST_OUT);
  assign out_digest_word = cv_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 4'(NumWords - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      pos_r  <= 4'd0;
      len_r  <= 64'h0;
      rnd_r  <= 7'd0;
      oidx_r <= 4'd0;
      pad_r  <= 1'b0;
      pend_r <= 1'b0;
      hi_r   <= 1'b0;
      fin_r  <= 1'b0;
      cv_r   <= IV_TAB;
    end else begin
      st_r   <= st_nxt;
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      rnd_r  <= rnd_nxt;
      oidx_r <= oidx_nxt;
      pad_r  <= pad_nxt;
      pend_r <= pend_nxt;
      hi_r   <= hi_nxt;
      fin_r  <= fin_nxt;
      cv_r   <= cv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wv_r <= wv_nxt;
    if (we) begin
      buf_mem[pos_r] <= wdata;
    end
    ml_r <= buf_mem[RL_TAB[rd_rnd]];
    mr_r <= buf_mem[RR_TAB[rd_rnd]];
  end

endmodule

>>> rtl/ripemd320_hash_unit.sv
// RIPEMD-320 hash unit: a two-entry input queue feeding the compression engine.
// Each 16-word block is compressed after its last word; while it compresses,
// only the queue takes new words. The last word adds padding, one or two
// compressions and then ten digest beats. Synchronous active-low reset
// restores the initial chaining values and empties the queue; the block
// buffer itself is not cleared.
module ripemd320_hash_unit import rmd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [3:0]  out_word_index,
  output logic        out_last_word
);

  logic       q_valid, q_pop;
  rmd_entry_t q_entry;

  rmd_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_data_word(in_data_word), .in_byte_count(in_byte_count),
    .in_last_of_message(in_last_of_message),
    .q_valid(q_valid), .q_entry(q_entry), .q_pop(q_pop)
  );

  rmd_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_entry(q_entry), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );

endmodule

>>> rtl/rmd_checker.sv
// Port-level checker for the RIPEMD-320 hash unit, bound to the top level.
// No dependencies.
module rmd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [3:0]  out_word_index,
  input logic        out_last_word
);

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word_index <= 4'd9))
    else $error("digest word index out of range");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 4'd9)))
    else $error("last word flag does not match index");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_word) |=>
      (out_valid && out_word_index == $past(out_word_index) + 4'd1))
    else $error("digest words not emitted in order");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_digest_word)))
    else $error("stalled digest beat changed");

endmodule

bind ripemd320_hash_unit rmd_checker u_rmd_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_digest_word(out_digest_word), .out_word_index(out_word_index),
  .out_last_word(out_last_word)
);

>>> bench/tb_ripemd320_hash_unit.sv
// Testbench for the RIPEMD-320 hash unit: drives messages as word beats and
// checks every digest word against a behavioural digest predictor.
// Depends on rmd_pkg (constant tables) and ripemd320_hash_unit.
`timescale 1ns / 1ps
module tb_ripemd320_hash_unit;
  import rmd_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic [3:0]  idx;
    logic        lastw;
  } digest_beat_t;

  typedef struct {
    logic [31:0] data;
    logic [2:0]  cnt;
    logic        lst;
    logic        known;
    logic [31:0] d0;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_data_word = '0;
  logic [2:0]  in_byte_count = '0;
  logic        in_last_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [3:0]  out_word_index;
  logic        out_last_word;

  ripemd320_hash_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0]  chain_q [10];
  logic [31:0]  blk_q [16];
  int           pos_q;
  logic [63:0]  bitlen_q;
  digest_beat_t digest_fifo [$];
  int           errors = 0;
  int           hold_off = 0;
  bit           hold_req = 0;
  bit           hold_done = 0;
  bit           calm = 0;
  bit           stim_done = 0;
  longint       cycles = 0;

  function automatic logic [31:0] rl32(logic [31:0] x, int n);
    return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
  endfunction

  function automatic logic [31:0] mix(int j, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if (j < 16) return x ^ y ^ z;
    if (j < 32) return (x & y) | (~x & z);
    if (j < 48) return (x | ~y) ^ z;
    if (j < 64) return (x & z) | (y & ~z);
    return x ^ (y | ~z);
  endfunction

  task automatic compress_block();
    logic [31:0] w [10];
    logic [31:0] t;
    int s;
    foreach (w[k]) w[k] = chain_q[k];
    for (int j = 0; j < 80; j++) begin
      t = rl32(w[0] + mix(j, w[1], w[2], w[3]) + blk_q[RL_TAB[j]] + KL_TAB[j / 16],
               SL_TAB[j]) + w[4];
      w[0] = w[4]; w[4] = w[3]; w[3] = rl32(w[2], 10); w[2] = w[1]; w[1] = t;
      t = rl32(w[5] + mix(79 - j, w[6], w[7], w[8]) + blk_q[RR_TAB[j]] + KR_TAB[j / 16],
               SR_TAB[j]) + w[9];
      w[5] = w[9]; w[9] = w[8]; w[8] = rl32(w[7], 10); w[7] = w[6]; w[6] = t;
      s = (j == 15) ? 1 : (j == 31) ? 3 : (j == 47) ? 0 : (j == 63) ? 2 : (j == 79) ? 4 : -1;
      if (s >= 0) begin
        t = w[s]; w[s] = w[s + 5]; w[s + 5] = t;
      end
    end
    foreach (w[k]) chain_q[k] += w[k];
  endtask

  task automatic store_word(logic [31:0] v);
    blk_q[pos_q] = v;
    pos_q = (pos_q + 1) % 16;
    if (pos_q == 0) compress_block();
  endtask

  function automatic void digest_restart();
    foreach (chain_q[k]) chain_q[k] = IV_TAB[k];
    pos_q = 0;
    bitlen_q = '0;
  endfunction

  task automatic predict_digest(logic [31:0] data, logic [2:0] cnt_in, logic lst);
    int cnt;
    logic [31:0] mask;
    digest_beat_t b;
    cnt = (!lst || cnt_in > 4) ? 4 : cnt_in;
    if (!lst) begin
      bitlen_q += 32;
      store_word(data);
      return;
    end
    bitlen_q += cnt * 8;
    if (cnt == 4) begin
      store_word(data);
      store_word(32'h80);
    end else begin
      mask = (cnt == 0) ? 32'h0 : (32'hFFFF_FFFF >> (32 - 8 * cnt));
      store_word((data & mask) | (32'h80 << (8 * cnt)));
    end
    if (pos_q > 14) store_word('0);
    while (pos_q < 14) store_word('0);
    store_word(bitlen_q[31:0]);
    store_word(bitlen_q[63:32]);
    for (int k = 0; k < 10; k++) begin
      b.word = chain_q[k]; b.idx = 4'(k); b.lastw = (k == 9);
      digest_fifo = {digest_fifo, b};
    end
    digest_restart();
  endtask

  task automatic send_word(logic [31:0] data, logic [2:0] cnt, logic lst);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_word <= data;
    in_byte_count <= cnt;
    in_last_of_message <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_digest(data, cnt, lst);
  endtask

  task automatic send_message(int words);
    for (int i = 0; i < words - 1; i++)
      send_word($urandom, $urandom_range(0, 7), 1'b0);
    send_word($urandom, $urandom_range(0, 7), 1'b1);
  endtask

  // Receiver: random stalls, and one long hold-off so the input queue fills.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_off <= 300;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      hold_off <= $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    digest_beat_t e;
    if (rst_n && out_valid && out_ready) begin
      if (digest_fifo.size() == 0) begin
        $error("digest beat with nothing expected: word %h", out_digest_word);
        errors++;
      end else begin
        e = digest_fifo.pop_front();
        if (out_digest_word !== e.word) begin
          $error("digest_word expected %h actual %h", e.word, out_digest_word);
          errors++;
        end
        if (out_word_index !== e.idx) begin
          $error("word_index expected %0d actual %0d", e.idx, out_word_index);
          errors++;
        end
        if (out_last_word !== e.lastw) begin
          $error("last_word expected %0d actual %0d", e.lastw, out_last_word);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  stim_row_t rows [$];

  initial begin
    int lens;
    int words;
    digest_restart();
    // Empty message digest's first word is a known value.
    rows = {rows, stim_row_t'{32'h0, 3'd0, 1'b1, 1'b1, 32'h565dd622}};
    rows = {rows, stim_row_t'{32'hFFFF_FFFF, 3'd0, 1'b1, 1'b0, 32'h0}};
    for (int c = 1; c <= 7; c++)
      rows = {rows, stim_row_t'{32'hFFFF_FFFF, 3'(c), 1'b1, 1'b0, 32'h0}};
    rows = {rows, stim_row_t'{32'h0000_0000, 3'd4, 1'b1, 1'b0, 32'h0}};
    for (int i = 0; i < 13; i++)
      rows = {rows, stim_row_t'{(i % 2) ? 32'hFFFF_FFFF : 32'h0, 3'(i % 8), 1'b0, 1'b0,
                                32'h0}};
    rows = {rows, stim_row_t'{32'h0063_6261, 3'd3, 1'b1, 1'b0, 32'h0}};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[r]) begin
      if (rows[r].known && rows[r].lst)
        if (chain_q[0] + 32'h0 !== IV_TAB[0]) $error("predictor not at reset");
      send_word(rows[r].data, rows[r].cnt, rows[r].lst);
      if (rows[r].known && digest_fifo[0].word !== rows[r].d0) begin
        $error("digest_word expected %h actual %h", rows[r].d0, digest_fifo[0].word);
        errors++;
      end
    end
    // Long receiver hold-off while messages keep coming.
    hold_req = 1;
    send_message(20);
    send_message(1);
    lens = 0;
    while (lens < 300) begin
      case ($urandom_range(0, 3))
        0: words = $urandom_range(1, 3);
        1: words = $urandom_range(13, 18);
        2: words = $urandom_range(29, 33);
        default: words = $urandom_range(1, 12);
      endcase
      send_message(words);
      lens = lens + words;
      if (lens > 240) calm = 1;
    end
    in_valid <= 1'b0;
    stim_done = 1;
    while (digest_fifo.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rmd_pkg.sv
rtl/rmd_front.sv
rtl/rmd_back.sv
rtl/ripemd320_hash_unit.sv
rtl/rmd_checker.sv
bench/tb_ripemd320_hash_unit.sv
